### rtl/lkv_pkg.sv
// Shared types and constants for the LRU key-value cache.
// Used by every module under rtl/; it depends on nothing else.
package lkv_pkg;

  localparam int KEY_W   = 32;
  localparam int DATA_W  = 32;
  localparam int CAP_W   = 5;

  localparam int ENTRIES_DEFAULT = 16;

  localparam logic [CAP_W-1:0]  CAP_RESET = 5'd16;
  localparam logic [DATA_W-1:0] READ_MISS = '1;
  localparam logic [DATA_W-1:0] READ_PUT  = '0;

  typedef enum logic {
    MODE_GET = 1'b0,
    MODE_PUT = 1'b1
  } lkv_mode_t;

  typedef struct packed {
    lkv_mode_t                 mode;
    logic signed [KEY_W-1:0]   key;
    logic signed [DATA_W-1:0]  value;
  } lkv_req_t;

  typedef struct packed {
    logic                      hit;
    logic signed [DATA_W-1:0]  read_value;
  } lkv_res_t;

endpackage

### rtl/lru_key_value_cache.sv
// Top level of the fully associative LRU key-value cache.
// Depends on lkv_pkg, lkv_in_stage, lkv_core and lkv_out_stage.
//
//   channel  direction  handshake          payload
//   in_      request    in_valid/in_stall  in_mode, in_key, in_value
//   out_     result     out_valid/out_stall out_hit, out_read_value
//   cfg_     register   cfg_valid/cfg_ready cfg_capacity
//
// A request waits in the request register until the result register can
// take it, then is matched, updated and written there; one transaction
// can enter every cycle while the result is not stalled. The rate is set
// by the key compare against all entries and the rank update.
// Synchronous reset clears valid bits, ranks and the occupancy count.
// A stalled result holds the result register, which in turn stalls input.
module lru_key_value_cache #(
  parameter int ENTRIES = lkv_pkg::ENTRIES_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [0:0]                        in_mode,
  input  logic signed [lkv_pkg::KEY_W-1:0]  in_key,
  input  logic signed [lkv_pkg::DATA_W-1:0] in_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [0:0]                        out_hit,
  output logic signed [lkv_pkg::DATA_W-1:0] out_read_value,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lkv_pkg::CAP_W-1:0]         cfg_capacity
);

  logic [lkv_pkg::CAP_W-1:0] capacity_r;
  lkv_pkg::lkv_req_t         in_req, q_req;
  lkv_pkg::lkv_res_t         core_res, out_res;
  logic                      q_valid, can_load, advance;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= lkv_pkg::CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity_r <= cfg_capacity;
    end
  end

  assign in_req.mode  = lkv_pkg::lkv_mode_t'(in_mode);
  assign in_req.key   = in_key;
  assign in_req.value = in_value;

  assign advance = q_valid && can_load;

  lkv_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .advance  (advance),
    .q_valid  (q_valid),
    .q_req    (q_req)
  );

  lkv_core #(
    .ENTRIES (ENTRIES)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (advance),
    .req      (q_req),
    .capacity (capacity_r),
    .res      (core_res)
  );

  lkv_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .res       (core_res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_hit        = out_res.hit;
  assign out_read_value = out_res.read_value;

endmodule

### rtl/lkv_in_stage.sv
// Request register in front of the cache lookup.
// Depends on lkv_pkg for the request type.
module lkv_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lkv_pkg::lkv_req_t in_req,
  input  logic              advance,
  output logic              q_valid,
  output lkv_pkg::lkv_req_t q_req
);

  logic              q_valid_r, q_valid_nxt;
  lkv_pkg::lkv_req_t q_req_r;
  logic              accept;

  assign in_stall = q_valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    q_valid_nxt = q_valid_r;
    if (accept) begin
      q_valid_nxt = 1'b1;
    end else if (advance) begin
      q_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_valid_r <= 1'b0;
    end else begin
      q_valid_r <= q_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_req_r <= in_req;
    end
  end

  assign q_valid = q_valid_r;
  assign q_req   = q_req_r;

endmodule

### rtl/lkv_out_stage.sv
// Result register that holds a finished transaction until it is taken.
// Depends on lkv_pkg for the result type.
module lkv_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  lkv_pkg::lkv_res_t res,
  output logic              can_load,
  output logic              out_valid,
  input  logic              out_stall,
  output lkv_pkg::lkv_res_t out_res
);

  logic              valid_r, valid_nxt;
  lkv_pkg::lkv_res_t res_r;

  assign can_load = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

### rtl/lkv_core.sv
// Entry store, parallel key match and recency-rank update of the cache.
// Depends on lkv_pkg for request and result types and field widths.
module lkv_core #(
  parameter int ENTRIES = lkv_pkg::ENTRIES_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      go,
  input  lkv_pkg::lkv_req_t         req,
  input  logic [lkv_pkg::CAP_W-1:0] capacity,
  output lkv_pkg::lkv_res_t         res
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (CNT_W > lkv_pkg::CAP_W) ? CNT_W : lkv_pkg::CAP_W;

  logic [ENTRIES-1:0]              valid_r, valid_nxt;
  logic [IDX_W-1:0]                rank_r   [ENTRIES];
  logic [IDX_W-1:0]                rank_nxt [ENTRIES];
  logic [lkv_pkg::KEY_W-1:0]       key_r    [ENTRIES];
  logic [lkv_pkg::DATA_W-1:0]      data_r   [ENTRIES];
  logic [CNT_W-1:0]                occ_r, occ_nxt;

  logic [ENTRIES-1:0]              match;
  logic [ENTRIES-1:0]              victim;
  logic                            hit;
  logic [IDX_W-1:0]                hit_idx, free_idx, victim_idx, slot;
  logic [lkv_pkg::DATA_W-1:0]      hit_data;
  logic [IDX_W-1:0]                hit_rank, victim_rank, touch_rank;
  logic [CMP_W-1:0]                cap_w, eff_cap;
  logic                            evict, shift_all, is_put, touch, fill;

  assign is_put = (req.mode == lkv_pkg::MODE_PUT);

  // Capacity zero behaves as one; anything above the entry count is clipped.
  always_comb begin
    cap_w = CMP_W'(capacity);
    if (cap_w == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_w > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end else begin
      eff_cap = cap_w;
    end
  end

  assign evict = (CMP_W'(occ_r) >= eff_cap);

  // Valid ranks are always 0..occ-1 without gaps, so the least recent entry
  // is the one ranked occ-1.
  assign victim_rank = IDX_W'(occ_r - CNT_W'(1));

  always_comb begin
    hit_idx    = '0;
    free_idx   = '0;
    victim_idx = '0;
    hit_data   = '0;
    hit_rank   = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      match[i]  = valid_r[i] && (key_r[i] == req.key);
      victim[i] = valid_r[i] && (rank_r[i] == victim_rank);
      if (match[i]) begin
        hit_idx = IDX_W'(i);
      end
      if (!valid_r[i]) begin
        free_idx = IDX_W'(i);
      end
      if (victim[i]) begin
        victim_idx = IDX_W'(i);
      end
    end
    // Keys are unique, so at most one entry matches and an OR of the
    // selected entries is the read.
    for (int i = 0; i < ENTRIES; i++) begin
      if (match[i]) begin
        hit_data = hit_data | data_r[i];
        hit_rank = hit_rank | rank_r[i];
      end
    end
  end

  assign hit        = |match;
  assign slot       = hit ? hit_idx : (evict ? victim_idx : free_idx);
  assign touch_rank = hit ? hit_rank : victim_rank;
  assign shift_all  = !hit && !evict;
  assign touch      = go && (hit || is_put);
  assign fill       = go && is_put && !hit && !evict;

  always_comb begin
    valid_nxt = valid_r;
    occ_nxt   = occ_r;
    for (int i = 0; i < ENTRIES; i++) begin
      rank_nxt[i] = rank_r[i];
    end
    if (touch) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (IDX_W'(i) == slot) begin
          rank_nxt[i] = '0;
        end else if (valid_r[i] && (shift_all || (rank_r[i] < touch_rank))) begin
          rank_nxt[i] = rank_r[i] + IDX_W'(1);
        end
      end
      if (is_put) begin
        valid_nxt[slot] = 1'b1;
      end
    end
    if (fill) begin
      occ_nxt = occ_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      occ_r   <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      valid_r <= valid_nxt;
      occ_r   <= occ_nxt;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= rank_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && is_put) begin
      key_r[slot]  <= req.key;
      data_r[slot] <= req.value;
    end
  end

  always_comb begin
    res.hit = hit;
    if (is_put) begin
      res.read_value = lkv_pkg::READ_PUT;
    end else if (hit) begin
      res.read_value = hit_data;
    end else begin
      res.read_value = lkv_pkg::READ_MISS;
    end
  end

  // A key is never stored twice.
  a_unique_match: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match))
    else $error("more than one entry matches the key");

  // The fill count tracks the number of valid entries.
  a_occ_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == 32'(occ_r))
    else $error("occupancy count disagrees with valid entries");

  // With any entry in use, exactly one of them is least recent.
  a_one_victim: assert property (@(posedge clk) disable iff (!rst_n)
    (occ_r != '0) |-> $onehot(victim))
    else $error("recency ranks lost their order");

  // After a put, the entry it touched is valid and most recent.
  a_put_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (go && is_put) |=> (valid_r[$past(slot)] && (rank_r[$past(slot)] == '0)))
    else $error("put did not leave its entry most recent");

endmodule
